// File: rtl/aprc_pkg.sv
// ----------------------------------------------------------------------------
// Aging peer route cache package
// Shared widths, command codes, the queued request type and the back-end
// state type.
// ----------------------------------------------------------------------------
package aprc_pkg;

   localparam int ENTRIES       = 16;
   localparam int IDX_W         = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam int CMD_W         = 2;
   localparam int PEER_W        = 48;
   localparam int IPV4_W        = 32;
   localparam int TIME_W        = 64;
   localparam int AGE_W         = 32;

   localparam int REQ_DATA_W    = PEER_W + IPV4_W + TIME_W;
   localparam int RSP_FIELDS_W  = 2 + IPV4_W;
   localparam int RSP_DATA_W    = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [AGE_W-1:0] MAX_AGE_RESET = AGE_W'(30000);

   typedef enum logic [CMD_W-1:0] {
      CMD_LOOKUP  = 2'd0,
      CMD_OBSERVE = 2'd1,
      CMD_ADVANCE = 2'd2,
      CMD_NOP     = 2'd3
   } cmd_type;

   typedef struct packed {
      logic              lookup;
      logic              timed;
      logic              learn;
      logic [PEER_W-1:0] peer_id;
      logic [IPV4_W-1:0] route_ipv4;
      logic [TIME_W-1:0] now_ms;
   } work_type;

   typedef enum logic {
      BK_EVAL,
      BK_COMMIT
   } back_state_type;

endpackage

// File: rtl/aprc_front.sv
// ----------------------------------------------------------------------------
// Aging peer route cache front end
// Accepts requests, decodes the command into work flags and pushes the
// decoded request into the queue.
// ----------------------------------------------------------------------------
module aprc_front
   import aprc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [CMD_W-1:0]      req_tuser,
   output logic                  push_valid,
   input  logic                  push_ready,
   output work_type              push_data
);

   always_comb begin
      push_data            = '0;
      push_data.peer_id    = req_tdata[PEER_W-1:0];
      push_data.route_ipv4 = req_tdata[PEER_W+IPV4_W-1:PEER_W];
      push_data.now_ms     = req_tdata[REQ_DATA_W-1:PEER_W+IPV4_W];
      case (cmd_type'(req_tuser))
         CMD_LOOKUP: begin
            push_data.lookup = 1'b1;
         end
         CMD_OBSERVE: begin
            push_data.timed = 1'b1;
            push_data.learn = 1'b1;
         end
         CMD_ADVANCE: begin
            push_data.timed = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;

   assert property (@(posedge clock) disable iff (reset)
      push_valid |-> ($countones({push_data.lookup, push_data.timed}) <= 1))
      else $error("A request decoded as both a lookup and a timed command.");

   assert property (@(posedge clock) disable iff (reset)
      push_data.learn |-> push_data.timed)
      else $error("An observe request was decoded without its time advance.");

   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> (push_valid && push_ready))
      else $error("An accepted request did not enter the queue.");

endmodule

// File: rtl/aprc_queue.sv
// ----------------------------------------------------------------------------
// Aging peer route cache request queue
// A short register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module aprc_queue
   import aprc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  work_type push_data,
   output logic     pop_valid,
   input  logic     pop_ready,
   output work_type pop_data
);

   work_type            slot_ff [QUEUE_DEPTH];
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic                push_fire;
   logic                pop_fire;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/aprc_back.sv
// ----------------------------------------------------------------------------
// Aging peer route cache back end
// Holds the route table, the current time and the replacement pointer, and
// executes one queued request in an evaluate step and a commit step.
// ----------------------------------------------------------------------------
module aprc_back
   import aprc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [AGE_W-1:0]      csr_data,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  work_type              pop_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [PEER_W-1:0]     peer_ff  [ENTRIES];
   logic [IPV4_W-1:0]     ipv4_ff  [ENTRIES];
   logic [TIME_W-1:0]     seen_ff  [ENTRIES];
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [IDX_W-1:0]      ptr_ff, ptr_in;
   logic [TIME_W-1:0]     current_ms_ff, current_ms_in;
   logic [AGE_W-1:0]      max_age_ff;

   back_state_type        state_ff, state_in;
   logic [ENTRIES-1:0]    fresh_ff, fresh_in;
   logic [ENTRIES-1:0]    match_ff, match_in;
   logic                  late_ff, late_in;
   logic                  eval_load;
   logic                  commit;
   logic                  out_free;

   logic                  hit_any;
   logic [IDX_W-1:0]      hit_idx;
   logic [IDX_W-1:0]      slot;
   logic                  write_en;
   logic                  status_bit;
   logic                  hit_bit;
   logic [IPV4_W-1:0]     found_ipv4;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in  = state_ff;
      eval_load = 1'b0;
      commit    = 1'b0;
      case (state_ff)
         BK_EVAL: begin
            if (pop_valid) begin
               eval_load = 1'b1;
               state_in  = BK_COMMIT;
            end
         end
         BK_COMMIT: begin
            if (out_free) begin
               commit   = 1'b1;
               state_in = BK_EVAL;
            end
         end
         default: begin
            state_in = BK_EVAL;
         end
      endcase
   end

   assign pop_ready = commit;

   // Lookups age entries against the stored time, timed commands against the new time.
   always_comb begin
      logic [TIME_W-1:0] tsel;
      logic [TIME_W:0]   diff;
      logic              expired;
      tsel    = pop_data.lookup ? current_ms_ff : pop_data.now_ms;
      late_in = (pop_data.now_ms < current_ms_ff);
      for (int i = 0; i < ENTRIES; i++) begin
         diff        = {1'b0, tsel} - {1'b0, seen_ff[i]};
         expired     = diff[TIME_W] || (diff[TIME_W-1:0] >= TIME_W'(max_age_ff));
         fresh_in[i] = valid_ff[i] && !expired;
         match_in[i] = fresh_in[i] && (peer_ff[i] == pop_data.peer_id);
      end
   end

   always_comb begin
      hit_any = 1'b0;
      hit_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_any = 1'b1;
            hit_idx = IDX_W'(i);
         end
      end
      slot          = hit_any ? hit_idx : ptr_ff;
      valid_in      = valid_ff;
      ptr_in        = ptr_ff;
      current_ms_in = current_ms_ff;
      write_en      = 1'b0;
      if (commit && pop_data.timed && !late_ff) begin
         current_ms_in = pop_data.now_ms;
         valid_in      = fresh_ff;
         if (pop_data.learn) begin
            write_en       = 1'b1;
            valid_in[slot] = 1'b1;
            if (!hit_any) begin
               ptr_in = (ptr_ff == IDX_W'(ENTRIES - 1)) ? '0 : ptr_ff + 1'b1;
            end
         end
      end
      status_bit = pop_data.timed && late_ff;
      hit_bit    = pop_data.lookup && hit_any;
      found_ipv4 = hit_bit ? ipv4_ff[hit_idx] : '0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_EVAL;
         valid_ff      <= '0;
         ptr_ff        <= '0;
         current_ms_ff <= '0;
         max_age_ff    <= MAX_AGE_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         ptr_ff        <= ptr_in;
         current_ms_ff <= current_ms_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write) begin
            max_age_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (eval_load) begin
         fresh_ff <= fresh_in;
         match_ff <= match_in;
         late_ff  <= late_in;
      end
      if (write_en) begin
         peer_ff[slot] <= pop_data.peer_id;
         ipv4_ff[slot] <= pop_data.route_ipv4;
         seen_ff[slot] <= pop_data.now_ms;
      end
      if (commit) begin
         rsp_data_ff <= {{(RSP_DATA_W - RSP_FIELDS_W){1'b0}}, found_ipv4, hit_bit, status_bit};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_tvalid)
      else $error("A committed request produced no response.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_COMMIT) |-> ((match_ff & ~fresh_ff) == '0))
      else $error("A peer match was flagged on an entry that is not fresh.");

   assert property (@(posedge clock) disable iff (reset)
      (commit && pop_data.timed && late_ff) |=> $stable(current_ms_ff))
      else $error("A rejected request changed the current time.");

   assert property (@(posedge clock) disable iff (reset)
      (commit && pop_data.learn && !late_ff) |=> (valid_ff != '0))
      else $error("An accepted observe left the table empty.");

   assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (current_ms_ff >= $past(current_ms_ff)))
      else $error("The current time moved backwards.");

endmodule

// File: rtl/aging_peer_route_cache_core.sv
// ----------------------------------------------------------------------------
// Aging peer route cache core
// Maps 48-bit peer identities to IPv4 addresses with time-based aging.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ stream: tuser carries the command (lookup,
// observe or advance) and tdata carries the peer, the address and the time.
// Every request yields exactly one response on the rsp_ stream, in order,
// carrying the status, the hit flag and the found address.
// The maximum age is written through the csr_ channel, which is always ready;
// write it only while no request is in flight.
// A request is decoded by the front end and queued in a two-entry FIFO. The
// back end compares all sixteen table entries in parallel in its evaluate
// step and registers the response in its commit step; it pops no new
// request until the current one has committed, so the sustained rate is set
// by the evaluate and commit steps on the shared table.
// If the receiver stalls, the response waits in the output register, the
// queue keeps taking requests until it is full, and then req_tready drops.
// Reset clears all valid bits, the pointer and the current time, and sets
// the maximum age to 30000 ms; the core is ready in the cycle after reset.
// ----------------------------------------------------------------------------
module aging_peer_route_cache_core
   import aprc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // peer_id [47:0], route_ipv4 [79:48], now_ms [143:80]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // cmd [1:0]
   input  logic [CMD_W-1:0]      req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status [0], hit [1], found_ipv4 [33:2], zero fill [39:34]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [AGE_W-1:0]      csr_data
);

   logic     push_valid;
   logic     push_ready;
   work_type push_data;
   logic     pop_valid;
   logic     pop_ready;
   work_type pop_data;

   assign csr_ready = 1'b1;

   aprc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   aprc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   aprc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid && csr_ready),
      .csr_data   (csr_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: tb/sv/aging_peer_route_cache_checker.sv
// ----------------------------------------------------------------------------
// Aging peer route cache checker
// Watches the request, response and max-age write channels of the core,
// keeps its own copy of the route table and clock, and compares every
// response field by field against the oldest predicted reply.
// ----------------------------------------------------------------------------
module aging_peer_route_cache_checker
   import aprc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [CMD_W-1:0]      req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [AGE_W-1:0]      csr_data,
   output int                    mismatches,
   output int                    pending,
   output int                    hit_total,
   output int                    reject_total
);

   typedef struct packed {
      logic              status;
      logic              hit;
      logic [IPV4_W-1:0] found_ipv4;
   } route_reply_type;

   route_reply_type   expected_replies[$];

   logic [PEER_W-1:0] slot_peer  [ENTRIES];
   logic [IPV4_W-1:0] slot_addr  [ENTRIES];
   logic [TIME_W-1:0] slot_stamp [ENTRIES];
   logic              slot_live  [ENTRIES];
   int                victim_ptr;
   logic [TIME_W-1:0] clock_ms;
   logic [AGE_W-1:0]  age_limit;

   int                fail_count = 0;
   int                hits = 0;
   int                rejects = 0;

   function automatic logic slot_stale(int i, logic [TIME_W-1:0] t);
      return (t < slot_stamp[i]) || ((t - slot_stamp[i]) >= TIME_W'(age_limit));
   endfunction

   function automatic logic advance_clock(logic [TIME_W-1:0] t);
      if (t < clock_ms) begin
         return 1'b0;
      end
      clock_ms = t;
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_live[i] && slot_stale(i, t)) begin
            slot_live[i] = 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic route_reply_type predict_reply(cmd_type cmd,
                                                     logic [REQ_DATA_W-1:0] data);
      logic [PEER_W-1:0] peer;
      logic [IPV4_W-1:0] addr;
      logic [TIME_W-1:0] t;
      route_reply_type   r;
      int                slot;
      peer = data[PEER_W-1:0];
      addr = data[PEER_W +: IPV4_W];
      t    = data[PEER_W+IPV4_W +: TIME_W];
      r    = '0;
      slot = -1;
      case (cmd)
         CMD_LOOKUP: begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot < 0 && slot_live[i] && !slot_stale(i, clock_ms) &&
                   slot_peer[i] == peer) begin
                  slot = i;
               end
            end
            if (slot >= 0) begin
               r.hit        = 1'b1;
               r.found_ipv4 = slot_addr[slot];
            end
         end
         CMD_OBSERVE: begin
            if (!advance_clock(t)) begin
               r.status = 1'b1;
            end else begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (slot < 0 && slot_live[i] && slot_peer[i] == peer) begin
                     slot = i;
                  end
               end
               if (slot < 0) begin
                  slot       = victim_ptr;
                  victim_ptr = (victim_ptr == ENTRIES - 1) ? 0 : victim_ptr + 1;
               end
               slot_peer[slot]  = peer;
               slot_addr[slot]  = addr;
               slot_stamp[slot] = t;
               slot_live[slot]  = 1'b1;
            end
         end
         CMD_ADVANCE: begin
            if (!advance_clock(t)) begin
               r.status = 1'b1;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      fail_count++;
      $display("mismatch at %0t: %s, got %0h, expected %0h", $time, what, got, want);
   endtask

   always @(posedge clock) begin
      route_reply_type want;
      route_reply_type got;
      if (reset) begin
         foreach (slot_live[i]) begin
            slot_live[i]  = 1'b0;
            slot_peer[i]  = '0;
            slot_addr[i]  = '0;
            slot_stamp[i] = '0;
         end
         victim_ptr = 0;
         clock_ms   = '0;
         age_limit  = MAX_AGE_RESET;
         expected_replies.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            age_limit = csr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status     = rsp_tdata[0];
            got.hit        = rsp_tdata[1];
            got.found_ipv4 = rsp_tdata[2 +: IPV4_W];
            if (expected_replies.size() == 0) begin
               report_mismatch("response with no request outstanding", 64'(rsp_tdata), '0);
            end else begin
               want = expected_replies.pop_front();
               if (got.status != want.status) begin
                  report_mismatch("status", 64'(got.status), 64'(want.status));
               end
               if (got.hit != want.hit) begin
                  report_mismatch("hit", 64'(got.hit), 64'(want.hit));
               end
               if (got.found_ipv4 != want.found_ipv4) begin
                  report_mismatch("found_ipv4", 64'(got.found_ipv4),
                                  64'(want.found_ipv4));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            want = predict_reply(cmd_type'(req_tuser), req_tdata);
            expected_replies.push_back(want);
            if (want.hit) begin
               hits++;
            end
            if (want.status) begin
               rejects++;
            end
         end
      end
      mismatches   <= fail_count;
      pending      <= expected_replies.size();
      hit_total    <= hits;
      reject_total <= rejects;
   end

endmodule

// File: tb/sv/aging_peer_route_cache_core_tb.sv
// ----------------------------------------------------------------------------
// Aging peer route cache core testbench
// Drives lookup, observe, advance and unused requests in random bursts while
// the response side stalls in its own rhythm, steps the max age through its
// extremes between phases, and leaves all checking to the attached checker.
// ----------------------------------------------------------------------------
module aging_peer_route_cache_core_tb;
   import aprc_pkg::*;

   localparam int POOL = 24;

   typedef enum {RX_OPEN, RX_CHOPPY, RX_LONG_STALLS} rx_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0]      req_tuser = CMD_LOOKUP;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [AGE_W-1:0]      csr_data = '0;

   int                    mismatches;
   int                    pending;
   int                    hit_total;
   int                    reject_total;

   logic [AGE_W-1:0]      age_cfg = MAX_AGE_RESET;
   logic [TIME_W-1:0]     cur_ms = '0;
   logic [PEER_W-1:0]     peer_pool[POOL];
   logic [AGE_W-1:0]      age_plan[7];
   int                    cmd_count[4] = '{0, 0, 0, 0};
   int                    age_writes = 0;
   int                    burst_left = 0;

   rx_mode_type           rx_mode = RX_OPEN;
   int                    rx_mode_left = 0;
   int                    rx_hold = 0;

   aging_peer_route_cache_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   aging_peer_route_cache_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .mismatches   (mismatches),
      .pending      (pending),
      .hit_total    (hit_total),
      .reject_total (reject_total)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode      = rx_mode_type'($urandom_range(0, 2));
         rx_mode_left = $urandom_range(20, 150);
      end else begin
         rx_mode_left--;
      end
      case (rx_mode)
         RX_OPEN: begin
            rsp_tready <= 1'b1;
         end
         RX_CHOPPY: begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            if (rx_hold > 0) begin
               rx_hold--;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
               rx_hold = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 15) : 0;
            end
         end
      endcase
   end

   function automatic logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = a + b;
      return s[TIME_W] ? '1 : s[TIME_W-1:0];
   endfunction

   // Times mostly move forward by a fraction of the max age, sometimes stay
   // put, sometimes land on the expiry edge or far past it, and now and then
   // go backwards.
   function automatic logic [TIME_W-1:0] pick_time();
      logic [TIME_W-1:0] span;
      logic [TIME_W-1:0] r;
      int                sel;
      span = (age_cfg == 0) ? TIME_W'(3) : TIME_W'(age_cfg);
      r    = {$urandom, $urandom};
      sel  = $urandom_range(0, 99);
      if (sel < 8 && cur_ms != 0) begin
         return cur_ms - 1 - (r % cur_ms);
      end
      if (sel < 25) begin
         return cur_ms;
      end
      if (sel < 75) begin
         return sat_add(cur_ms, r % (span / 4 + 1));
      end
      if (sel < 92) begin
         return sat_add(cur_ms, (span > 2) ? span - 2 + r % 4 : r % 4);
      end
      return sat_add(cur_ms, sat_add(span, r % (span + 1)));
   endfunction

   task automatic send_request(cmd_type cmd, logic [PEER_W-1:0] peer,
                               logic [IPV4_W-1:0] addr, logic [TIME_W-1:0] t);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {t, addr, peer};
      do @(posedge clock); while (!req_tready);
      if ((cmd == CMD_OBSERVE || cmd == CMD_ADVANCE) && t >= cur_ms) begin
         cur_ms = t;
      end
      cmd_count[cmd]++;
   endtask

   task automatic wait_for_replies();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max_age(logic [AGE_W-1:0] value);
      wait_for_replies();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      age_cfg = value;
      age_writes++;
   endtask

   task automatic random_request();
      cmd_type           cmd;
      logic [PEER_W-1:0] peer;
      int                sel;
      sel  = $urandom_range(0, 99);
      cmd  = (sel < 40) ? CMD_LOOKUP : (sel < 75) ? CMD_OBSERVE :
             (sel < 95) ? CMD_ADVANCE : CMD_NOP;
      peer = ($urandom_range(0, 9) == 0) ? PEER_W'({$urandom, $urandom})
                                         : peer_pool[$urandom_range(0, POOL - 1)];
      if (cmd == CMD_LOOKUP || cmd == CMD_NOP) begin
         send_request(cmd, peer, $urandom, {$urandom, $urandom});
      end else begin
         send_request(cmd, peer, $urandom, pick_time());
      end
      if ($urandom_range(0, 79) == 0) begin
         wait_for_replies();
      end
   endtask

   initial begin
      peer_pool[0] = '0;
      peer_pool[1] = '1;
      for (int i = 2; i < POOL; i++) begin
         peer_pool[i] = PEER_W'({$urandom, $urandom});
      end
      age_plan = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd1000,
                   AGE_W'($urandom_range(2, 100000)), 32'd5, MAX_AGE_RESET};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_request(CMD_LOOKUP,  '0, '1, '1);
      send_request(CMD_OBSERVE, '1, '1, '0);
      send_request(CMD_LOOKUP,  '1, '0, '0);
      send_request(CMD_OBSERVE, '0, '0, 64'd10);
      send_request(CMD_LOOKUP,  '0, '1, '1);
      send_request(CMD_NOP,     '1, '1, '1);
      send_request(CMD_OBSERVE, '1, 32'h0A00_0001, 64'd20);
      send_request(CMD_LOOKUP,  '1, '0, '0);
      send_request(CMD_ADVANCE, '0, '0, 64'd5);
      send_request(CMD_OBSERVE, 48'h1234, 32'h1, 64'd9);
      send_request(CMD_ADVANCE, '0, '0, 64'd30009);
      send_request(CMD_LOOKUP,  '0, '0, '0);
      send_request(CMD_ADVANCE, '0, '0, 64'd30010);
      send_request(CMD_LOOKUP,  '0, '0, '0);
      send_request(CMD_LOOKUP,  '1, '0, '0);
      send_request(CMD_ADVANCE, '1, '1, 64'd30010);

      foreach (age_plan[p]) begin
         write_max_age(age_plan[p]);
         repeat (170) random_request();
      end

      send_request(CMD_ADVANCE, '0, '0, 64'hFFFF_FFFF_FFFF_0000);
      repeat (150) random_request();
      send_request(CMD_ADVANCE, '0, '0, '1);
      send_request(CMD_OBSERVE, peer_pool[3], 32'hC0A8_0001, '1);
      send_request(CMD_LOOKUP,  peer_pool[3], '0, '0);
      send_request(CMD_ADVANCE, '0, '0, '0);

      wait_for_replies();
      repeat (20) @(posedge clock);

      $display("Covered %0d lookups, %0d observes, %0d advances and %0d unused commands",
               cmd_count[CMD_LOOKUP], cmd_count[CMD_OBSERVE], cmd_count[CMD_ADVANCE],
               cmd_count[CMD_NOP]);
      $display("over %0d max-age writes; %0d lookups hit, %0d timed requests refused.",
               age_writes, hit_total, reject_total);
      if (mismatches == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("simulation failed");
      $finish;
   end

endmodule

// File: filelist.f
rtl/aprc_pkg.sv
rtl/aprc_front.sv
rtl/aprc_queue.sv
rtl/aprc_back.sv
rtl/aging_peer_route_cache_core.sv
tb/sv/aging_peer_route_cache_checker.sv
tb/sv/aging_peer_route_cache_core_tb.sv
